// ===== rtl/core/nixie_scan_pwm_timer_core_defines.svh =====
// Assertion macros shared by the display scanner and PWM timer modules.
`ifndef NIXIE_SCAN_PWM_TIMER_CORE_DEFINES_SVH
`define NIXIE_SCAN_PWM_TIMER_CORE_DEFINES_SVH

// Checks a consequence in the same cycle as its condition.
`define NSPT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nspt assertion failed");

// Checks a consequence in the cycle after its condition.
`define NSPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nspt assertion failed");

`endif

// ===== rtl/core/nspt_pkg.sv =====
// Types and constants of the display scanner and PWM timer.
package nspt_pkg;

    localparam int ANODE_LINES = 4;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [2:0] CFG_PWM_PERIOD = 3'd0;
    localparam logic [2:0] CFG_PWM_DUTY   = 3'd1;
    localparam logic [2:0] CFG_MS_DIVIDE  = 3'd2;
    localparam logic [2:0] CFG_LIT_TICKS  = 3'd3;
    localparam logic [2:0] CFG_DARK_TICKS = 3'd4;

    localparam logic [15:0] RST_PWM_PERIOD = 16'd100;
    localparam logic [15:0] RST_PWM_DUTY   = 16'd0;
    localparam logic [7:0]  RST_MS_DIVIDE  = 8'd30;
    localparam logic [7:0]  RST_LIT_TICKS  = 8'd80;
    localparam logic [7:0]  RST_DARK_TICKS = 8'd40;

    typedef struct packed {
        logic [15:0] pwm_period;
        logic [15:0] pwm_duty;
        logic [7:0]  ms_divide;
        logic [7:0]  lit_ticks;
        logic [7:0]  dark_ticks;
    } cfg_t;

    typedef struct packed {
        logic       pwm_out;
        logic       ms_strobe;
        logic [3:0] anode_select;
        logic [3:0] bcd_code;
    } result_t;

endpackage

// ===== rtl/core/nspt_cfg_regs.sv =====
// Configuration registers of the display scanner and PWM timer.
module nspt_cfg_regs
    import nspt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pwm_period <= RST_PWM_PERIOD;
            cfg_reg.pwm_duty   <= RST_PWM_DUTY;
            cfg_reg.ms_divide  <= RST_MS_DIVIDE;
            cfg_reg.lit_ticks  <= RST_LIT_TICKS;
            cfg_reg.dark_ticks <= RST_DARK_TICKS;
        end else if (wr_en) begin
            case (wr_index)
                CFG_PWM_PERIOD: cfg_reg.pwm_period <= wr_data;
                CFG_PWM_DUTY:   cfg_reg.pwm_duty   <= wr_data;
                CFG_MS_DIVIDE:  cfg_reg.ms_divide  <= wr_data[7:0];
                CFG_LIT_TICKS:  cfg_reg.lit_ticks  <= wr_data[7:0];
                CFG_DARK_TICKS: cfg_reg.dark_ticks <= wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/nspt_timers.sv =====
// PWM counter, millisecond divider, display phase counter and digit store.
`include "nixie_scan_pwm_timer_core_defines.svh"

module nspt_timers
    import nspt_pkg::*;
#(
    parameter int NUM_DIGITS = 4
)(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       req_type,
    input  logic [1:0] digit_index,
    input  logic [3:0] digit_value,
    input  cfg_t       cfg,
    output result_t    result_next
);

    localparam int SCAN_W = $clog2(NUM_DIGITS);

    logic [15:0]       period_count_reg, period_count_next;
    logic [15:0]       duty_count_reg, duty_count_next;
    logic              pwm_level_reg, pwm_level_next;
    logic [7:0]        ms_count_reg, ms_count_next;
    logic [7:0]        phase_count_reg, phase_count_next;
    logic              in_dark_reg, in_dark_next;
    logic [SCAN_W-1:0] scan_index_reg, scan_index_next;
    logic [3:0]        select_reg, select_next;
    logic [3:0]        code_reg, code_next;
    logic [3:0]        digit_store_reg [NUM_DIGITS];

    logic [15:0]       period_dec;
    logic [15:0]       duty_dec;
    logic [7:0]        ms_dec;
    logic [7:0]        phase_dec;
    logic              strobe;
    logic [SCAN_W+1:0] write_index;
    logic              write_en;
    logic              is_tick;

    assign is_tick     = (req_type == REQ_TICK);
    assign period_dec  = period_count_reg - 16'd1;
    assign duty_dec    = duty_count_reg - 16'd1;
    assign ms_dec      = ms_count_reg - 8'd1;
    assign phase_dec   = phase_count_reg - 8'd1;
    assign write_index = {{SCAN_W{1'b0}}, digit_index};
    assign write_en    = step && (req_type == REQ_WRITE)
                         && (write_index < (SCAN_W + 2)'(NUM_DIGITS));

    always_comb begin
        period_count_next = period_count_reg;
        duty_count_next   = duty_count_reg;
        pwm_level_next    = pwm_level_reg;
        ms_count_next     = ms_count_reg;
        phase_count_next  = phase_count_reg;
        in_dark_next      = in_dark_reg;
        scan_index_next   = scan_index_reg;
        select_next       = select_reg;
        code_next         = code_reg;
        strobe            = 1'b0;
        if (is_tick) begin
            if (period_dec == 16'd0) begin
                period_count_next = cfg.pwm_period;
                if (cfg.pwm_duty == 16'd0) begin
                    pwm_level_next = 1'b0;
                end else begin
                    pwm_level_next  = 1'b1;
                    duty_count_next = cfg.pwm_duty;
                end
            end else begin
                period_count_next = period_dec;
                if (pwm_level_reg && (cfg.pwm_duty < cfg.pwm_period)) begin
                    duty_count_next = duty_dec;
                    if (duty_dec == 16'd0) begin
                        pwm_level_next = 1'b0;
                    end
                end
            end

            if (ms_dec == 8'd0) begin
                ms_count_next = cfg.ms_divide;
                strobe        = 1'b1;
            end else begin
                ms_count_next = ms_dec;
            end

            phase_count_next = phase_dec;
            if (phase_dec == 8'd0) begin
                if (in_dark_reg) begin
                    select_next      = 4'd0;
                    in_dark_next     = 1'b0;
                    phase_count_next = cfg.dark_ticks;
                end else begin
                    if ({{(32 - SCAN_W){1'b0}}, scan_index_reg} < 32'(ANODE_LINES)) begin
                        select_next = 4'b0001 << scan_index_reg;
                    end else begin
                        select_next = 4'd0;
                    end
                    code_next        = digit_store_reg[scan_index_reg];
                    in_dark_next     = 1'b1;
                    phase_count_next = cfg.lit_ticks;
                    if (scan_index_reg == SCAN_W'(NUM_DIGITS - 1)) begin
                        scan_index_next = '0;
                    end else begin
                        scan_index_next = scan_index_reg + SCAN_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg <= 16'd1;
            duty_count_reg   <= 16'd0;
            pwm_level_reg    <= 1'b0;
            ms_count_reg     <= RST_MS_DIVIDE;
            phase_count_reg  <= RST_LIT_TICKS;
            in_dark_reg      <= 1'b1;
            scan_index_reg   <= '0;
            select_reg       <= 4'd0;
            code_reg         <= 4'd0;
        end else if (step) begin
            period_count_reg <= period_count_next;
            duty_count_reg   <= duty_count_next;
            pwm_level_reg    <= pwm_level_next;
            ms_count_reg     <= ms_count_next;
            phase_count_reg  <= phase_count_next;
            in_dark_reg      <= in_dark_next;
            scan_index_reg   <= scan_index_next;
            select_reg       <= select_next;
            code_reg         <= code_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digit_store_reg[i] <= 4'd0;
            end
        end else if (write_en) begin
            digit_store_reg[write_index[SCAN_W-1:0]] <= digit_value;
        end
    end

    assign result_next.pwm_out      = pwm_level_next;
    assign result_next.ms_strobe    = strobe;
    assign result_next.anode_select = select_next;
    assign result_next.bcd_code     = code_next;

    `NSPT_ASSERT_SAME(a_no_strobe_on_write, !is_tick, !strobe)
    `NSPT_ASSERT_NEXT(a_write_keeps_counters, step && !is_tick,
        $stable(period_count_reg) && $stable(ms_count_reg) && $stable(phase_count_reg))

endmodule

// ===== rtl/core/nixie_scan_pwm_timer_core.sv =====
// Top level of the multiplexed display scanner with PWM and millisecond divider.
//
// Usage: the s_ channel carries items, either a timer tick or a digit write
// (digit_index, digit_value). Each accepted item yields exactly one result item
// on the m_ channel: the PWM level, the millisecond strobe of that tick, the
// one-hot (or all-zero) anode select and the BCD code, all as they stand after the item.
// The cfg_ channel writes the five timing registers by index; it is always
// ready and is meant to be used only while no item is in flight.
// Order: an accepted item waits in the input register until the result
// register can take it, and the result register then captures its result;
// a stall on m_ready can hold the item in the input register.
// Throughput: one item per clock cycle while m_ready stays high; the counter
// update between the input register and the result register is a single pass.
// Reset: aresetn low for one edge restores the register defaults, empties
// both stages and clears the digit store.
// Stall: while m_ready is low the result is held; the input register still
// takes one more item, after which s_ready drops until the result is taken.
`include "nixie_scan_pwm_timer_core_defines.svh"

module nixie_scan_pwm_timer_core
    import nspt_pkg::*;
#(
    parameter int NUM_DIGITS = 4
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [1:0]  s_digit_index,
    input  logic [3:0]  s_digit_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pwm_out,
    output logic        m_ms_strobe,
    output logic [3:0]  m_anode_select,
    output logic [3:0]  m_bcd_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic       in_valid_reg;
    logic       in_req_type_reg;
    logic [1:0] in_digit_index_reg;
    logic [3:0] in_digit_value_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    cfg_t       cfg;
    logic       advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    nspt_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    nspt_timers #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_timers (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .req_type    (in_req_type_reg),
        .digit_index (in_digit_index_reg),
        .digit_value (in_digit_value_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_type_reg    <= s_req_type;
            in_digit_index_reg <= s_digit_index;
            in_digit_value_reg <= s_digit_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_pwm_out      = result_reg.pwm_out;
    assign m_ms_strobe    = result_reg.ms_strobe;
    assign m_anode_select = result_reg.anode_select;
    assign m_bcd_code     = result_reg.bcd_code;

    `NSPT_ASSERT_NEXT(a_in_item_kept, in_valid_reg && !advance, in_valid_reg)
    `NSPT_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg)
    `NSPT_ASSERT_SAME(a_select_onehot0, out_valid_reg, $onehot0(result_reg.anode_select))

endmodule

// ===== sim/tb_nixie_scan_pwm_timer_core.sv =====
// Self-checking testbench for the nixie display scanner and PWM timer core.
module tb_nixie_scan_pwm_timer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import nspt_pkg::*;

    localparam int DIGITS       = 4;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 95;

    class scan_tracker;
        cfg_t        regs;
        logic [15:0] period_left;
        logic [15:0] duty_left;
        logic        level;
        logic [7:0]  ms_left;
        logic [7:0]  phase_left;
        logic        dark_next;
        int unsigned scan;
        logic [3:0]  digits [DIGITS];
        logic [3:0]  anodes;
        logic [3:0]  code;
        result_t     outstanding [$];
        int          failures;

        function new();
            regs.pwm_period = RST_PWM_PERIOD;
            regs.pwm_duty   = RST_PWM_DUTY;
            regs.ms_divide  = RST_MS_DIVIDE;
            regs.lit_ticks  = RST_LIT_TICKS;
            regs.dark_ticks = RST_DARK_TICKS;
            period_left = 16'd1;
            duty_left   = 16'd0;
            level       = 1'b0;
            ms_left     = RST_MS_DIVIDE;
            phase_left  = RST_LIT_TICKS;
            dark_next   = 1'b1;
            scan        = 0;
            foreach (digits[i]) digits[i] = 4'd0;
            anodes   = 4'd0;
            code     = 4'd0;
            failures = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_PWM_PERIOD: regs.pwm_period = data;
                CFG_PWM_DUTY:   regs.pwm_duty   = data;
                CFG_MS_DIVIDE:  regs.ms_divide  = data[7:0];
                CFG_LIT_TICKS:  regs.lit_ticks  = data[7:0];
                CFG_DARK_TICKS: regs.dark_ticks = data[7:0];
                default: ;
            endcase
        endfunction

        function void take_item(logic req, logic [1:0] idx, logic [3:0] val);
            result_t r;
            logic    strobe;
            strobe = 1'b0;
            if (req == REQ_WRITE) begin
                if (idx < DIGITS) digits[idx] = val;
            end else begin
                period_left = period_left - 16'd1;
                if (period_left == 16'd0) begin
                    period_left = regs.pwm_period;
                    if (regs.pwm_duty == 16'd0) begin
                        level = 1'b0;
                    end else begin
                        level     = 1'b1;
                        duty_left = regs.pwm_duty;
                    end
                end else if (level && regs.pwm_duty < regs.pwm_period) begin
                    duty_left = duty_left - 16'd1;
                    if (duty_left == 16'd0) level = 1'b0;
                end

                ms_left = ms_left - 8'd1;
                if (ms_left == 8'd0) begin
                    ms_left = regs.ms_divide;
                    strobe  = 1'b1;
                end

                phase_left = phase_left - 8'd1;
                if (phase_left == 8'd0) begin
                    if (dark_next) begin
                        anodes     = 4'd0;
                        dark_next  = 1'b0;
                        phase_left = regs.dark_ticks;
                    end else begin
                        anodes     = (scan < ANODE_LINES) ? 4'(1 << scan) : 4'd0;
                        code       = digits[scan];
                        dark_next  = 1'b1;
                        phase_left = regs.lit_ticks;
                        scan       = (scan + 1 >= DIGITS) ? 0 : scan + 1;
                    end
                end
            end
            r.pwm_out      = level;
            r.ms_strobe    = strobe;
            r.anode_select = anodes;
            r.bcd_code     = code;
            outstanding.push_back(r);
        endfunction

        function void compare(string name, logic [3:0] want, logic [3:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                failures++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (outstanding.size() == 0) begin
                $display("%0t ns: result with no item pending, actual %0d %0d %0d %0d",
                         $time, got.pwm_out, got.ms_strobe, got.anode_select, got.bcd_code);
                failures++;
                return;
            end
            want = outstanding.pop_front();
            compare("pwm_out", 4'(want.pwm_out), 4'(got.pwm_out));
            compare("ms_strobe", 4'(want.ms_strobe), 4'(got.ms_strobe));
            compare("anode_select", want.anode_select, got.anode_select);
            compare("bcd_code", want.bcd_code, got.bcd_code);
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_req_type    = REQ_TICK;
    logic [1:0]  s_digit_index = 2'd0;
    logic [3:0]  s_digit_value = 4'd0;
    logic        m_ready       = 1'b1;
    logic        cfg_valid     = 1'b0;
    logic [2:0]  cfg_index     = CFG_PWM_PERIOD;
    logic [15:0] cfg_data      = 16'd0;
    logic        s_ready;
    logic        m_valid;
    logic        m_pwm_out;
    logic        m_ms_strobe;
    logic [3:0]  m_anode_select;
    logic [3:0]  m_bcd_code;
    logic        cfg_ready;

    scan_tracker tracker;
    int          idle_pct     = 20;
    bit          calm         = 1'b0;
    bit          hold_request = 1'b0;
    int          cycle_count  = 0;

    always #1 aclk = ~aclk;

    nixie_scan_pwm_timer_core #(
        .NUM_DIGITS(DIGITS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_digit_index  (s_digit_index),
        .s_digit_value  (s_digit_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pwm_out      (m_pwm_out),
        .m_ms_strobe    (m_ms_strobe),
        .m_anode_select (m_anode_select),
        .m_bcd_code     (m_bcd_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    function automatic cfg_t make_cfg(int p, int d, int m, int l, int k);
        cfg_t c;
        c.pwm_period = 16'(p);
        c.pwm_duty   = 16'(d);
        c.ms_divide  = 8'(m);
        c.lit_ticks  = 8'(l);
        c.dark_ticks = 8'(k);
        return c;
    endfunction

    task automatic send_item(logic req, logic [1:0] idx, logic [3:0] val);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_digit_index <= idx;
        s_digit_value <= val;
        do @(posedge aclk); while (!s_ready);
        tracker.take_item(req, idx, val);
    endtask

    task automatic send_random();
        logic req;
        req = ($urandom_range(0, 99) < 20) ? REQ_WRITE : REQ_TICK;
        send_item(req, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.outstanding.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_setting(cfg_t c);
        logic [2:0]  idxs [5];
        logic [15:0] vals [5];
        idxs = '{CFG_PWM_PERIOD, CFG_PWM_DUTY, CFG_MS_DIVIDE, CFG_LIT_TICKS, CFG_DARK_TICKS};
        vals = '{c.pwm_period, c.pwm_duty, 16'(c.ms_divide), 16'(c.lit_ticks),
                 16'(c.dark_ticks)};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            tracker.set_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.pwm_out      = m_pwm_out;
            got.ms_strobe    = m_ms_strobe;
            got.anode_select = m_anode_select;
            got.bcd_code     = m_bcd_code;
            tracker.match_result(got);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        cfg_t plan [$];
        tracker = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Field extremes and both request kinds under the reset timing.
        send_item(REQ_WRITE, 2'd0, 4'd9);
        send_item(REQ_WRITE, 2'd1, 4'd10);
        send_item(REQ_WRITE, 2'd2, 4'd15);
        send_item(REQ_WRITE, 2'd3, 4'd0);
        repeat (4) send_item(REQ_TICK, 2'd0, 4'd0);
        send_item(REQ_WRITE, 2'd3, 4'd15);
        send_item(REQ_WRITE, 2'd0, 4'd0);
        send_item(REQ_TICK, 2'd3, 4'd15);
        repeat (6) send_item(REQ_TICK, 2'd2, 4'd5);
        send_item(REQ_WRITE, 2'd1, 4'd1);
        send_item(REQ_WRITE, 2'd2, 4'd8);
        repeat (184) send_random();

        plan.push_back(make_cfg(1, 0, 1, 1, 1));
        plan.push_back(make_cfg(1, 1, 1, 1, 1));
        plan.push_back(make_cfg(4, 2, 3, 2, 3));
        plan.push_back(make_cfg(5, 65535, 255, 255, 255));
        plan.push_back(make_cfg(65535, 3, 2, 1, 2));
        plan.push_back(make_cfg(7, 7, 4, 3, 1));
        plan.push_back(make_cfg(10, 9, 1, 2, 5));
        plan.push_back(make_cfg($urandom_range(1, 20), $urandom_range(0, 24),
                                $urandom_range(1, 10), $urandom_range(1, 8),
                                $urandom_range(1, 8)));
        plan.push_back(make_cfg($urandom_range(1, 20), $urandom_range(0, 24),
                                $urandom_range(1, 10), $urandom_range(1, 8),
                                $urandom_range(1, 8)));
        plan.push_back(make_cfg(6, 3, 5, 2, 2));

        foreach (plan[p]) begin
            drain();
            if (p == plan.size() - 1) begin
                calm     = 1'b1;
                idle_pct = 0;
            end else begin
                idle_pct = (p % 3 == 1) ? 0 : 25;
            end
            apply_setting(plan[p]);
            if (p == 2) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == PHASE_ITEMS / 2) drain();
                send_random();
            end
        end
        drain();

        if (tracker.failures == 0 && tracker.outstanding.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
